// ----- rtl/sapq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapq_pkg
// Shared types and constants for the sorted-array priority queue.
// ----------------------------------------------------------------------------
package sapq_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int COUNT_BITS  = 5;
    localparam int CAP_BITS    = 5;

    localparam logic [CAP_BITS-1:0] CAPACITY_RESET = 5'd16;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef logic signed [VALUE_BITS-1:0] t_value;

    typedef struct packed {
        logic   kind;
        t_value value;
    } t_in_beat;

    typedef struct packed {
        t_status                status;
        logic [COUNT_BITS-1:0]  fill_count;
        t_value                 head_value;
    } t_out_beat;

    // Operation strobes broadcast to every cell.
    typedef struct packed {
        logic ins_en;
        logic del_en;
    } t_cell_op;

    // Where a cell sits relative to the stored run.
    typedef struct packed {
        logic occupied;
        logic tail;
    } t_cell_slot;

endpackage

// ----- rtl/sapq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapq_cell
// One slot of the sorted chain: holds a value, compares it with the
// broadcast operand and shifts to or from its neighbors.
// ----------------------------------------------------------------------------
module sapq_cell (
    input  logic                 i_clk,
    input  sapq_pkg::t_cell_op   i_op,
    input  sapq_pkg::t_cell_slot i_slot,
    input  sapq_pkg::t_value     i_value,
    input  logic                 i_left_ge,
    input  sapq_pkg::t_value     i_left_value,
    input  sapq_pkg::t_value     i_right_value,
    output logic                 o_ge,
    output logic                 o_hit,
    output sapq_pkg::t_value     o_value,
    output sapq_pkg::t_value     o_next_value
);

    sapq_pkg::t_value r_value;
    sapq_pkg::t_value n_value;

    // Operand at or above the stored value, only for live slots.
    assign o_ge    = i_slot.occupied && (i_value >= r_value);
    // First live slot that equals the operand (sorted, so equals are contiguous).
    assign o_hit   = i_slot.occupied && (i_value == r_value) && !i_left_ge;
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_op.ins_en && (o_ge || i_slot.tail)) begin
            // Take the left neighbor when it also shifts, else take the operand.
            n_value = i_left_ge ? i_left_value : i_value;
        end else if (i_op.del_en && o_ge) begin
            // Close the gap: pull from the right.
            n_value = i_right_value;
        end
    end

    assign o_next_value = n_value;

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

// ----- rtl/sorted_array_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_array_priority_queue
// Shift-register priority queue: signed values kept in descending order in
// a chain of cells, with insert and delete-by-value, one result per beat.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_ready  | i_in_data  (t_in_beat)
//  out     | output    | o_out_valid / i_out_ready| o_out_data (t_out_beat)
//  cfg     | input     | i_cfg_we                 | i_cfg_data (capacity)
//
//  Cycles: one beat per clock unless the output stalls; every cell compares
//  the operand against its own value in parallel and shifts in one step, so
//  the result is registered and appears in the cycle after the input beat is taken.
//  The output register lets a new beat in whenever it is empty or being
//  drained in the same cycle; a stalled output holds the input side.
//  Reset (synchronous, active low) clears the fill count and output valid
//  and sets capacity to 16. Cell contents are not cleared; slots at or past
//  the fill count are never read.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  sapq_pkg::t_in_beat                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output sapq_pkg::t_out_beat                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [sapq_pkg::CAP_BITS-1:0]       i_cfg_data
);

    // Count wide enough to hold DEPTH itself; compare width covers capacity too.
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > sapq_pkg::CAP_BITS) ? CW : sapq_pkg::CAP_BITS;

    logic [CW-1:0]                   r_count;
    logic [CW-1:0]                   n_count;
    logic [sapq_pkg::CAP_BITS-1:0]   r_capacity;
    logic                            r_out_valid;
    sapq_pkg::t_out_beat             r_out_data;
    sapq_pkg::t_out_beat             n_out_data;

    logic [CMPW-1:0]                 eff_cap;
    logic [CMPW-1:0]                 count_ext;
    logic                            accept;
    logic                            full;
    logic                            empty;
    logic                            found;
    sapq_pkg::t_cell_op              op;
    sapq_pkg::t_status               status;

    logic [DEPTH-1:0]                ge;
    logic [DEPTH-1:0]                hit;
    sapq_pkg::t_value                cell_value [DEPTH];
    sapq_pkg::t_value                cell_next  [DEPTH];

    // ------------------------------------------------------------------
    // Handshake: accept while the output register is free or draining.
    // ------------------------------------------------------------------
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Clamp capacity into 1..DEPTH.
    always_comb begin
        if (r_capacity == '0) begin
            eff_cap = CMPW'(1);
        end else if (CMPW'(r_capacity) > CMPW'(DEPTH)) begin
            eff_cap = CMPW'(DEPTH);
        end else begin
            eff_cap = CMPW'(r_capacity);
        end
    end

    assign count_ext = CMPW'(r_count);
    assign full      = count_ext >= eff_cap;
    assign empty     = (r_count == '0);
    assign found     = |hit;

    // Decide the operation; cells only move on a successful one.
    always_comb begin
        op     = '0;
        status = sapq_pkg::ST_OK;
        if (i_in_data.kind == sapq_pkg::KIND_INSERT) begin
            if (full) begin
                status = sapq_pkg::ST_OVERFLOW;
            end else begin
                op.ins_en = accept;
            end
        end else begin
            if (empty) begin
                status = sapq_pkg::ST_EMPTY;
            end else if (!found) begin
                status = sapq_pkg::ST_NOT_FOUND;
            end else begin
                op.del_en = accept;
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (op.ins_en) begin
            n_count = r_count + CW'(1);
        end else if (op.del_en) begin
            n_count = r_count - CW'(1);
        end
    end

    // ------------------------------------------------------------------
    // Cell chain. Each cell sees its left neighbor's compare flag and the
    // values on both sides; the ends are tied off.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        sapq_pkg::t_cell_slot slot;
        logic                 left_ge;
        sapq_pkg::t_value     left_value;
        sapq_pkg::t_value     right_value;

        assign slot.occupied = CW'(g) < r_count;
        assign slot.tail     = CW'(g) == r_count;

        if (g == 0) begin : g_head
            assign left_ge    = 1'b0;
            assign left_value = i_in_data.value;
        end else begin : g_body
            assign left_ge    = ge[g-1];
            assign left_value = cell_value[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            // Slot empties on delete; its content no longer matters.
            assign right_value = cell_value[g];
        end else begin : g_mid
            assign right_value = cell_value[g+1];
        end

        sapq_cell u_cell (
            .i_clk         (i_clk),
            .i_op          (op),
            .i_slot        (slot),
            .i_value       (i_in_data.value),
            .i_left_ge     (left_ge),
            .i_left_value  (left_value),
            .i_right_value (right_value),
            .o_ge          (ge[g]),
            .o_hit         (hit[g]),
            .o_value       (cell_value[g]),
            .o_next_value  (cell_next[g])
        );
    end

    // Result beat reflects the state after this operation.
    always_comb begin
        n_out_data.status     = status;
        n_out_data.fill_count = sapq_pkg::COUNT_BITS'(n_count);
        n_out_data.head_value = (n_count == '0) ? '0 : cell_next[0];
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_capacity  <= sapq_pkg::CAPACITY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: load on accept, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- rtl/sapq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapq_assertions
// Port-level checks for the sorted-array priority queue, bound to the top.
// ----------------------------------------------------------------------------
module sapq_assertions (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_ready,
    input  sapq_pkg::t_in_beat                  i_in_data,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  sapq_pkg::t_out_beat                 o_out_data
);

    // A taken input beat always yields a result beat next cycle.
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted beat produced no result");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed");

    // Empty queue reports a zero head.
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.fill_count == '0) |-> (o_out_data.head_value == '0))
        else $error("head nonzero with empty queue");

    // Empty status only with nothing stored.
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == sapq_pkg::ST_EMPTY)
            |-> (o_out_data.fill_count == '0))
        else $error("empty status with entries stored");

    // Reset drops the output beat.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind sorted_array_priority_queue sapq_assertions u_sapq_assertions (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
